>>> hw/rtl/c8core_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_pkg
// Shared constants, types and the font table of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int SCR_HEIGHT    = 32;
    localparam int SCR_WIDTH     = 64;
    localparam int STACK_ENTRIES = 16;

    localparam logic [11:0] FONT_BASE     = 12'h050;
    localparam logic [11:0] PROGRAM_START = 12'h200;
    localparam logic [6:0]  FONT_BYTES    = 7'd80;
    localparam logic [7:0]  TICK_RESET    = 8'd10;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  NN_SKP  = 8'h9E;
    localparam logic [7:0]  NN_SKNP = 8'hA1;
    localparam logic [7:0]  NN_GDLY = 8'h07;
    localparam logic [7:0]  NN_KEYW = 8'h0A;
    localparam logic [7:0]  NN_SDLY = 8'h15;
    localparam logic [7:0]  NN_SSND = 8'h18;
    localparam logic [7:0]  NN_ADDI = 8'h1E;
    localparam logic [7:0]  NN_FONT = 8'h29;
    localparam logic [7:0]  NN_BCD  = 8'h33;
    localparam logic [7:0]  NN_STOR = 8'h55;
    localparam logic [7:0]  NN_LOAD = 8'h65;

    // Output beat layout (tdata, highest bit first)
    typedef struct packed {
        logic [63:0] row_pixels;
        logic        waiting_for_key;
        logic        sound_on;
        logic        screen_changed;
        logic [15:0] executed_opcode;
        logic [11:0] program_counter;
    } result_t;

    function automatic logic [7:0] font_byte(input logic [6:0] i);
        logic [7:0] g [0:79];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (i < FONT_BYTES)
            return g[i];
        return 8'h00;
    endfunction

endpackage

>>> hw/rtl/c8core_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/c8core_bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_bcd
// Splits a byte into hundreds (compare-subtract), tens and ones (reciprocal).
// ----------------------------------------------------------------------------
module c8core_bcd (
    input  logic [7:0] value,
    output logic [3:0] hundreds,
    output logic [3:0] tens,
    output logic [3:0] ones
);

    logic [6:0] rem_h;
    logic [6:0] q10;

    // Hundreds take at most two steps
    always_comb
    begin
        if (value >= 8'd200)
        begin
            hundreds = 4'd2;
            rem_h    = 7'(value - 8'd200);
        end
        else if (value >= 8'd100)
        begin
            hundreds = 4'd1;
            rem_h    = 7'(value - 8'd100);
        end
        else
        begin
            hundreds = 4'd0;
            rem_h    = value[6:0];
        end
        // Divide by ten through a reciprocal (exact for values below 100)
        q10  = 7'((15'(rem_h) * 15'd205) >> 11);
        tens = q10[3:0];
        ones = 4'(rem_h - 7'(q10 * 7'd10));
    end

endmodule

>>> hw/rtl/chip8_instruction_core_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_top
// CHIP-8 core: main memory and screen in synchronous RAM, sequenced execute.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         kind, address, data, row, keys, random_byte
//  m_axis    out        program_counter, opcode, flags, row_pixels
//  cfg       in         steps_per_timer_tick write
//
//  After reset the sequencer copies the font and clears both memories;
//  no beat is accepted meanwhile.
//  The length of an execute is set by the one byte-wide memory port (fetch,
//  sprite, block moves) and the one-row screen port (a draw reads and writes
//  back each sprite row, a clear each screen row).
//  One beat is in flight at a time; a held result does not stop the next
//  input being taken into the sequencer until a new result is due.
// ----------------------------------------------------------------------------
module chip8_instruction_core_top #(
    parameter int MEMORY_BYTES  = c8core_pkg::MEM_BYTES,
    parameter int SCREEN_HEIGHT = c8core_pkg::SCR_HEIGHT,
    parameter int STACK_DEPTH   = c8core_pkg::STACK_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // address[11:0], data[19:12], row[24:20], keys[40:25], random_byte[48:41]
    input  logic [55:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // program_counter[11:0], executed_opcode[27:12], screen_changed[28],
    // sound_on[29], waiting_for_key[30], row_pixels[94:31]
    output logic [95:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_LOAD, S_READ0, S_READ1, S_FETCH0, S_FETCH1, S_FETCH2,
        S_EXEC, S_CLS0, S_CLS1, S_DRAW0, S_DRAW1, S_DRAW2, S_DRAW3,
        S_BCD, S_STOR, S_LOAD0, S_LOAD1, S_DONE
    } state_t;

    state_t state_reg;
    logic [AW-1:0] init_reg;

    // Memory ports
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic          scr_we;
    logic [RW-1:0] scr_addr;
    logic [63:0]   scr_wdata, scr_rdata;

    c8core_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata));
    c8core_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_scr (
        .clk(clk), .we(scr_we), .addr(scr_addr), .wdata(scr_wdata), .rdata(scr_rdata));

    // Architectural registers
    logic [7:0]    v_reg [0:15];
    logic [11:0]   stk_reg [0:STACK_DEPTH-1];
    logic [SW-1:0] sp_reg;
    logic [11:0]   pc_reg, i_reg;
    logic [7:0]    dt_reg, st_reg, pre_reg, tick_reg;

    // Item latches
    logic [1:0]  kind_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg, rnd_reg;
    logic [4:0]  row_reg;
    logic [15:0] keys_reg;
    logic [15:0] op_reg;
    logic [4:0]  cnt_reg;
    logic        chg_reg, hit_reg, wait_reg;
    logic [63:0] pix_reg;
    logic [63:0] mask_reg;
    logic        out_valid_reg;
    c8core_pkg::result_t out_reg;

    logic [3:0] x, y, n;
    logic [7:0] nn, vx, vy;
    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign n  = op_reg[3:0];
    assign nn = op_reg[7:0];
    assign vx = v_reg[x];
    assign vy = v_reg[y];

    logic [3:0] bcd_h, bcd_t, bcd_o;
    c8core_bcd u_bcd (.value(vx), .hundreds(bcd_h), .tens(bcd_t), .ones(bcd_o));

    logic [11:0] pc2;
    assign pc2 = pc_reg + 12'd2;

    // Wrap the stack pointer at the stack depth
    logic [SW-1:0] sp_inc, sp_dec;
    assign sp_inc = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    // Rotate a sprite byte to its column
    logic [63:0] smask;
    always_comb
    begin
        smask = {mem_rdata, 56'd0} >> vx[5:0] | {mem_rdata, 56'd0} << (7'd64 - {1'b0, vx[5:0]});
        if (vx[5:0] == 6'd0)
            smask = {mem_rdata, 56'd0};
    end

    // Lowest pressed key
    logic [3:0] key_idx;
    always_comb
    begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--)
            if (keys_reg[k])
                key_idx = 4'(k);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

    // Memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = pc_reg;
        mem_wdata = 8'd0;
        scr_we    = 1'b0;
        scr_addr  = RW'(row_reg);
        scr_wdata = 64'd0;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_addr  = init_reg;
                mem_wdata = c8core_pkg::font_byte(7'(init_reg - c8core_pkg::FONT_BASE));
                if (init_reg < c8core_pkg::FONT_BASE
                    || init_reg >= c8core_pkg::FONT_BASE + 12'(c8core_pkg::FONT_BYTES))
                    mem_wdata = 8'd0;
                scr_we    = 1'b1;
                scr_addr  = RW'(init_reg);
            end
            S_LOAD:
            begin
                mem_we    = 1'b1;
                mem_addr  = addr_reg;
                mem_wdata = data_reg;
            end
            S_FETCH0: mem_addr = pc_reg;
            S_FETCH1: mem_addr = pc_reg + 12'd1;
            S_CLS0:   scr_addr = RW'(cnt_reg);
            S_CLS1:
            begin
                scr_we   = 1'b1;
                scr_addr = RW'(cnt_reg);
            end
            S_DRAW0:
            begin
                mem_addr = i_reg + 12'(cnt_reg);
            end
            S_DRAW1, S_DRAW2: scr_addr = RW'(vy + 8'(cnt_reg));
            S_DRAW3:
            begin
                scr_we    = 1'b1;
                scr_addr  = RW'(vy + 8'(cnt_reg));
                scr_wdata = scr_rdata ^ mask_reg;
            end
            S_BCD:
            begin
                mem_we    = 1'b1;
                mem_addr  = i_reg + 12'(cnt_reg);
                mem_wdata = (cnt_reg == 5'd0) ? {4'd0, bcd_h} :
                            (cnt_reg == 5'd1) ? {4'd0, bcd_t} : {4'd0, bcd_o};
            end
            S_STOR:
            begin
                mem_we    = 1'b1;
                mem_addr  = i_reg + 12'(cnt_reg);
                mem_wdata = v_reg[cnt_reg[3:0]];
            end
            S_LOAD0: mem_addr = i_reg + 12'(cnt_reg);
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            for (int k = 0; k < 16; k++)
                v_reg[k] <= 8'd0;
            for (int k = 0; k < STACK_DEPTH; k++)
                stk_reg[k] <= 12'd0;
            sp_reg        <= '0;
            pc_reg        <= c8core_pkg::PROGRAM_START;
            i_reg         <= 12'd0;
            dt_reg        <= 8'd0;
            st_reg        <= 8'd0;
            pre_reg       <= 8'd0;
            tick_reg      <= c8core_pkg::TICK_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                tick_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == AW'(MEMORY_BYTES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        kind_reg <= s_axis_tuser;
                        addr_reg <= s_axis_tdata[11:0];
                        data_reg <= s_axis_tdata[19:12];
                        row_reg  <= s_axis_tdata[24:20];
                        keys_reg <= s_axis_tdata[40:25];
                        rnd_reg  <= s_axis_tdata[48:41];
                        op_reg   <= 16'd0;
                        chg_reg  <= 1'b0;
                        wait_reg <= 1'b0;
                        pix_reg  <= 64'd0;
                        case (s_axis_tuser)
                            c8core_pkg::KIND_LOAD: state_reg <= S_LOAD;
                            c8core_pkg::KIND_EXEC: state_reg <= S_FETCH0;
                            c8core_pkg::KIND_READ: state_reg <= S_READ0;
                            default:               state_reg <= S_DONE;
                        endcase
                    end
                end
                S_LOAD:  state_reg <= S_DONE;
                S_READ0: state_reg <= S_READ1;
                S_READ1:
                begin
                    pix_reg   <= scr_rdata;
                    state_reg <= S_DONE;
                end
                S_FETCH0:
                begin
                    if (pre_reg >= tick_reg)
                    begin
                        if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                        if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                        pre_reg <= 8'd0;
                    end
                    state_reg <= S_FETCH1;
                end
                S_FETCH1:
                begin
                    op_reg[15:8] <= mem_rdata;
                    state_reg    <= S_FETCH2;
                end
                S_FETCH2:
                begin
                    op_reg[7:0] <= mem_rdata;
                    if (pre_reg != 8'hFF)
                        pre_reg <= pre_reg + 8'd1;
                    state_reg   <= S_EXEC;
                end
                S_EXEC:
                begin
                    pc_reg    <= pc2;
                    state_reg <= S_DONE;
                    cnt_reg   <= '0;
                    hit_reg   <= 1'b0;
                    case (op_reg[15:12])
                        4'h0:
                        begin
                            if (op_reg == c8core_pkg::OP_CLS)
                                state_reg <= S_CLS0;
                            else if (op_reg == c8core_pkg::OP_RET)
                            begin
                                sp_reg <= sp_dec;
                                pc_reg <= stk_reg[sp_dec];
                            end
                        end
                        4'h1: pc_reg <= op_reg[11:0];
                        4'h2:
                        begin
                            stk_reg[sp_reg] <= pc2;
                            sp_reg <= sp_inc;
                            pc_reg <= op_reg[11:0];
                        end
                        4'h3: if (vx == nn) pc_reg <= pc_reg + 12'd4;
                        4'h4: if (vx != nn) pc_reg <= pc_reg + 12'd4;
                        4'h5: if (vx == vy) pc_reg <= pc_reg + 12'd4;
                        4'h9: if (vx != vy) pc_reg <= pc_reg + 12'd4;
                        4'h6: v_reg[x] <= nn;
                        4'h7: v_reg[x] <= vx + nn;
                        4'h8:
                        begin
                            case (n)
                                4'h0: v_reg[x] <= vy;
                                4'h1: v_reg[x] <= vx | vy;
                                4'h2: v_reg[x] <= vx & vy;
                                4'h3: v_reg[x] <= vx ^ vy;
                                4'h4:
                                begin
                                    v_reg[x]  <= vx + vy;
                                    v_reg[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                                end
                                4'h5:
                                begin
                                    v_reg[x]  <= vx - vy;
                                    v_reg[15] <= {7'd0, vx >= vy};
                                end
                                4'h6:
                                begin
                                    v_reg[x]  <= vx >> 1;
                                    v_reg[15] <= {7'd0, vx[0]};
                                end
                                4'h7:
                                begin
                                    v_reg[x]  <= vy - vx;
                                    v_reg[15] <= {7'd0, vy >= vx};
                                end
                                4'hE:
                                begin
                                    v_reg[x]  <= vx << 1;
                                    v_reg[15] <= {7'd0, vx[7]};
                                end
                                default: ;
                            endcase
                        end
                        4'hA: i_reg <= op_reg[11:0];
                        4'hB: pc_reg <= op_reg[11:0] + {4'd0, v_reg[0]};
                        4'hC: v_reg[x] <= rnd_reg & nn;
                        4'hD:
                        begin
                            if (n == 4'd0)
                                v_reg[15] <= 8'd0;
                            else
                                state_reg <= S_DRAW0;
                        end
                        4'hE:
                        begin
                            if (nn == c8core_pkg::NN_SKP && keys_reg[vx[3:0]])
                                pc_reg <= pc_reg + 12'd4;
                            if (nn == c8core_pkg::NN_SKNP && !keys_reg[vx[3:0]])
                                pc_reg <= pc_reg + 12'd4;
                        end
                        4'hF:
                        begin
                            case (nn)
                                c8core_pkg::NN_GDLY: v_reg[x] <= dt_reg;
                                c8core_pkg::NN_SDLY: dt_reg <= vx;
                                c8core_pkg::NN_SSND: st_reg <= vx;
                                c8core_pkg::NN_ADDI: i_reg <= i_reg + {4'd0, vx};
                                c8core_pkg::NN_KEYW:
                                begin
                                    if (keys_reg != 16'd0)
                                        v_reg[x] <= {4'd0, key_idx};
                                    else
                                    begin
                                        pc_reg   <= pc_reg;
                                        wait_reg <= 1'b1;
                                    end
                                end
                                c8core_pkg::NN_BCD:  state_reg <= S_BCD;
                                c8core_pkg::NN_STOR: state_reg <= S_STOR;
                                c8core_pkg::NN_LOAD: state_reg <= S_LOAD0;
                                c8core_pkg::NN_FONT:
                                    i_reg <= c8core_pkg::FONT_BASE
                                             + 12'({vx, 2'b00}) + {4'd0, vx};
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
                // Clear screen: read each row, flag nonzero, write zero
                S_CLS0: state_reg <= S_CLS1;
                S_CLS1:
                begin
                    if (scr_rdata != 64'd0)
                        chg_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg == 5'(SCREEN_HEIGHT - 1)) ? S_DONE : S_CLS0;
                end
                // Sprite: read byte, read row, xor back
                S_DRAW0: state_reg <= S_DRAW1;
                S_DRAW1:
                begin
                    mask_reg  <= smask;
                    if (mem_rdata != 8'd0)
                        chg_reg <= 1'b1;
                    state_reg <= S_DRAW2;
                end
                S_DRAW2: state_reg <= S_DRAW3;
                S_DRAW3:
                begin
                    if ((scr_rdata & mask_reg) != 64'd0)
                        hit_reg <= 1'b1;
                    if (cnt_reg == 5'({1'b0, n}) - 5'd1)
                    begin
                        v_reg[15] <= {7'd0, hit_reg | ((scr_rdata & mask_reg) != 64'd0)};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_DRAW0;
                    end
                end
                S_BCD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd2)
                        state_reg <= S_DONE;
                end
                S_STOR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[3:0] == x)
                        state_reg <= S_DONE;
                end
                S_LOAD0: state_reg <= S_LOAD1;
                S_LOAD1:
                begin
                    v_reg[cnt_reg[3:0]] <= mem_rdata;
                    cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= (cnt_reg[3:0] == x) ? S_DONE : S_LOAD0;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_reg.program_counter <= pc_reg;
            out_reg.executed_opcode <= (kind_reg == c8core_pkg::KIND_EXEC) ? op_reg : 16'd0;
            out_reg.screen_changed  <= chg_reg;
            out_reg.sound_on        <= (st_reg != 8'd0);
            out_reg.waiting_for_key <= wait_reg;
            out_reg.row_pixels      <= pix_reg;
        end
    end

endmodule
